// File: rtl/bpc_pkg.sv
// Package for the button press classifier: phase codes, register indexes,
// event kinds, field widths and register reset values.
// No dependencies.
`default_nettype none

package bpc_pkg;

  localparam int DEB_W       = 10;
  localparam int LONG_W      = 16;
  localparam int LED_CNT_W   = 4;
  localparam int LED_IDX_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DEB_W-1:0]     DEB_MAX              = '1;
  localparam logic [DEB_W-1:0]     DEBOUNCE_TICKS_RESET = DEB_W'(50);
  localparam logic [LONG_W-1:0]    LONG_PRESS_RESET     = LONG_W'(750);
  localparam logic [LED_CNT_W-1:0] LED_COUNT_RESET      = LED_CNT_W'(3);

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_DEB_PRESS     = 3'd1,
    PH_HELD          = 3'd2,
    PH_DEB_REL_SHORT = 3'd3,
    PH_WAIT_REL      = 3'd4,
    PH_DEB_REL_LONG  = 3'd5
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE_TICKS   = 2'd0,
    REG_LONG_PRESS_TICKS = 2'd1,
    REG_LED_COUNT        = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    EV_MODE_CHANGE = 1'b0,
    EV_LED_SELECT  = 1'b1
  } event_kind_t;

endpackage

`default_nettype wire

// File: rtl/bpc_press_if.sv
// Input channel of the button press classifier: one sampled button level per item.
// Depends on nothing.
`default_nettype none

interface bpc_press_if;
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink   (input valid, input button_pressed, output ready);
endinterface

`default_nettype wire

// File: rtl/bpc_event_if.sv
// Result channel of the button press classifier: event kind and LED index.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_event_if;
  logic                        valid;
  logic                        ready;
  logic                        event_kind;
  logic [bpc_pkg::LED_IDX_W-1:0] led_index;

  modport source (output valid, output event_kind, output led_index, input ready);
  modport sink   (input valid, input event_kind, input led_index, output ready);
endinterface

`default_nettype wire

// File: rtl/bpc_cfg_if.sv
// Configuration write channel of the button press classifier.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpc_pkg::CFG_INDEX_W-1:0] index;
  logic [bpc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/button_press_classifier.sv
// Button press classifier top level: debounce, hold counter, LED selection,
// and a two-entry result buffer (output register plus skid register).
// Depends on bpc_pkg, bpc_press_if, bpc_event_if, bpc_cfg_if.
//
//   channel | dir | payload                      | handshake
//   press   | in  | button_pressed               | valid/ready
//   evt     | out | event_kind, led_index        | valid/ready
//   cfg     | in  | index, data                  | valid/ready, always ready
//
// One item per cycle while press.ready is high; each accepted item updates
// the phase, counters and selection in the same cycle, and any result lands
// in the output register, which drives evt, or in the skid register while
// the output register is stalled. press.ready drops only while both result
// registers are full, or during rst. rst (synchronous) clears phase, counters,
// selection, result buffer and returns the registers to 50, 750 and 3.
`default_nettype none

module button_press_classifier #(
  parameter int HOLD_COUNT_WIDTH = 16,
  parameter int LED_INDEX_WIDTH  = 4
) (
  input  wire          clk,
  input  wire          rst,
  bpc_press_if.sink    press,
  bpc_event_if.source  evt,
  bpc_cfg_if.sink      cfg
);

  localparam int HOLD_CMP_W = (HOLD_COUNT_WIDTH > bpc_pkg::LONG_W) ?
                              HOLD_COUNT_WIDTH : bpc_pkg::LONG_W;
  localparam int SEL_CMP_W  = (LED_INDEX_WIDTH > bpc_pkg::LED_CNT_W) ?
                              LED_INDEX_WIDTH : bpc_pkg::LED_CNT_W;
  localparam logic [HOLD_COUNT_WIDTH-1:0] HOLD_MAX = '1;

  logic [bpc_pkg::DEB_W-1:0]     debounce_ticks;
  logic [bpc_pkg::LONG_W-1:0]    long_press_ticks;
  logic [bpc_pkg::LED_CNT_W-1:0] led_count;

  bpc_pkg::phase_t               press_phase, press_phase_next;
  logic [bpc_pkg::DEB_W-1:0]     debounce_count, debounce_count_next;
  logic [HOLD_COUNT_WIDTH-1:0]   hold_count, hold_count_next;
  logic [LED_INDEX_WIDTH-1:0]    led_sel, led_sel_next;

  logic [HOLD_COUNT_WIDTH-1:0]   hold_inc;
  logic [bpc_pkg::DEB_W-1:0]     deb_inc;
  logic                          deb_done;
  logic                          hold_limit;
  logic                          sel_wrap;
  logic [SEL_CMP_W-1:0]          sel_ext;
  logic                          pressed;

  logic                          res_valid;
  bpc_pkg::event_kind_t          res_kind;
  logic [bpc_pkg::LED_IDX_W-1:0] res_index;

  logic                          out_valid;
  bpc_pkg::event_kind_t          out_kind;
  logic [bpc_pkg::LED_IDX_W-1:0] out_index;
  logic                          skid_valid;
  bpc_pkg::event_kind_t          skid_kind;
  logic [bpc_pkg::LED_IDX_W-1:0] skid_index;

  logic press_fire;
  logic evt_fire;
  logic push;

  assign press.ready = !skid_valid && !rst;
  assign cfg.ready   = 1'b1;
  assign press_fire  = press.valid && press.ready;
  assign evt_fire    = out_valid && evt.ready;
  assign push        = press_fire && res_valid;
  assign pressed     = press.button_pressed;

  assign hold_inc   = (hold_count != HOLD_MAX) ? hold_count + 1'b1 : hold_count;
  assign deb_inc    = (debounce_count != bpc_pkg::DEB_MAX) ?
                      debounce_count + 1'b1 : debounce_count;
  assign deb_done   = deb_inc >= debounce_ticks;
  assign hold_limit = HOLD_CMP_W'(hold_inc) >= HOLD_CMP_W'(long_press_ticks);
  assign sel_wrap   = SEL_CMP_W'(led_sel) >= SEL_CMP_W'(led_count);

  // phase transitions
  always_comb begin
    press_phase_next = press_phase;
    case (press_phase)
      bpc_pkg::PH_DEB_PRESS: begin
        if (!pressed) begin
          press_phase_next = bpc_pkg::PH_IDLE;
        end else if (deb_done) begin
          press_phase_next = bpc_pkg::PH_HELD;
        end
      end
      bpc_pkg::PH_HELD: begin
        if (hold_limit) begin
          press_phase_next = bpc_pkg::PH_WAIT_REL;
        end else if (!pressed) begin
          press_phase_next = bpc_pkg::PH_DEB_REL_SHORT;
        end
      end
      bpc_pkg::PH_DEB_REL_SHORT: begin
        if (pressed) begin
          press_phase_next = bpc_pkg::PH_HELD;
        end else if (deb_done) begin
          press_phase_next = bpc_pkg::PH_IDLE;
        end
      end
      bpc_pkg::PH_WAIT_REL: begin
        if (!pressed) begin
          press_phase_next = bpc_pkg::PH_DEB_REL_LONG;
        end
      end
      bpc_pkg::PH_DEB_REL_LONG: begin
        if (pressed) begin
          press_phase_next = bpc_pkg::PH_WAIT_REL;
        end else if (deb_done) begin
          press_phase_next = bpc_pkg::PH_IDLE;
        end
      end
      default: begin
        press_phase_next = pressed ? bpc_pkg::PH_DEB_PRESS : bpc_pkg::PH_IDLE;
      end
    endcase
  end

  // counters, selection and result
  always_comb begin
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    led_sel_next        = led_sel;
    res_valid           = 1'b0;
    res_kind            = bpc_pkg::EV_MODE_CHANGE;
    case (press_phase)
      bpc_pkg::PH_DEB_PRESS: begin
        hold_count_next = hold_inc;
        if (pressed) begin
          debounce_count_next = deb_inc;
        end
      end
      bpc_pkg::PH_HELD: begin
        hold_count_next = hold_inc;
        if (hold_limit) begin
          led_sel_next = sel_wrap ? '0 : led_sel + 1'b1;
          res_valid    = 1'b1;
          res_kind     = bpc_pkg::EV_LED_SELECT;
        end else if (!pressed) begin
          debounce_count_next = '0;
        end
      end
      bpc_pkg::PH_DEB_REL_SHORT: begin
        hold_count_next = hold_inc;
        if (!pressed) begin
          debounce_count_next = deb_inc;
          res_valid           = deb_done && (led_sel != '0);
        end
      end
      bpc_pkg::PH_WAIT_REL: begin
        if (!pressed) begin
          debounce_count_next = '0;
        end
      end
      bpc_pkg::PH_DEB_REL_LONG: begin
        if (!pressed) begin
          debounce_count_next = deb_inc;
        end
      end
      default: begin
        if (pressed) begin
          debounce_count_next = '0;
          hold_count_next     = '0;
        end
      end
    endcase
  end

  assign sel_ext   = SEL_CMP_W'(led_sel_next);
  assign res_index = sel_ext[bpc_pkg::LED_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bpc_pkg::DEBOUNCE_TICKS_RESET;
      long_press_ticks <= bpc_pkg::LONG_PRESS_RESET;
      led_count        <= bpc_pkg::LED_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        bpc_pkg::REG_DEBOUNCE_TICKS:
          debounce_ticks <= cfg.data[bpc_pkg::DEB_W-1:0];
        bpc_pkg::REG_LONG_PRESS_TICKS:
          long_press_ticks <= cfg.data[bpc_pkg::LONG_W-1:0];
        bpc_pkg::REG_LED_COUNT:
          led_count <= cfg.data[bpc_pkg::LED_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_phase    <= bpc_pkg::PH_IDLE;
      debounce_count <= '0;
      hold_count     <= '0;
      led_sel        <= '0;
    end else if (press_fire) begin
      press_phase    <= press_phase_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      led_sel        <= led_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (evt_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !evt_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (evt_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (evt_fire) begin
        out_kind  <= skid_kind;
        out_index <= skid_index;
      end
    end else if (push) begin
      if (out_valid && !evt_fire) begin
        skid_kind  <= res_kind;
        skid_index <= res_index;
      end else begin
        out_kind  <= res_kind;
        out_index <= res_index;
      end
    end
  end

  assign evt.valid      = out_valid;
  assign evt.event_kind = out_kind;
  assign evt.led_index  = out_index;

endmodule

`default_nettype wire

// File: rtl/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier.
`default_nettype none

module bpc_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          press_valid,
  input wire                          press_ready,
  input wire                          evt_valid,
  input wire                          evt_ready,
  input wire                          evt_event_kind,
  input wire [bpc_pkg::LED_IDX_W-1:0] evt_led_index
);

  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=>
      evt_valid && $stable(evt_event_kind) && $stable(evt_led_index))
    else $error("stalled event item changed");

  a_mode_led: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt_event_kind == bpc_pkg::EV_MODE_CHANGE) |-> evt_led_index != '0)
    else $error("mode change event without a selected LED");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("event pending after reset");

  a_evt_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(evt_valid) |-> $past(press_valid && press_ready))
    else $error("event appeared without an accepted press item");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk            (clk),
  .rst            (rst),
  .press_valid    (press.valid),
  .press_ready    (press.ready),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .evt_event_kind (evt.event_kind),
  .evt_led_index  (evt.led_index)
);

`default_nettype wire

// File: dv/tb_button_press_classifier.sv
// Testbench for button_press_classifier: directed press table, a maximum-settings run,
// a result-side back-pressure run, then random press/release sequences under several settings.
// Depends on bpc_pkg, bpc_press_if, bpc_event_if, bpc_cfg_if and the block itself.
`default_nettype none

module tb_button_press_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 100_000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 520;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DIR_ROWS       = 22;

  localparam logic [bpc_pkg::CFG_INDEX_W-1:0] R_DEB     = bpc_pkg::REG_DEBOUNCE_TICKS;
  localparam logic [bpc_pkg::CFG_INDEX_W-1:0] R_LONG    = bpc_pkg::REG_LONG_PRESS_TICKS;
  localparam logic [bpc_pkg::CFG_INDEX_W-1:0] R_LEDS    = bpc_pkg::REG_LED_COUNT;
  localparam logic [bpc_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam bpc_pkg::event_kind_t EV_MODE = bpc_pkg::EV_MODE_CHANGE;
  localparam bpc_pkg::event_kind_t EV_SEL  = bpc_pkg::EV_LED_SELECT;

  typedef struct packed {
    bpc_pkg::event_kind_t          kind;
    logic [bpc_pkg::LED_IDX_W-1:0] led;
  } led_event_t;

  typedef enum {ROW_CFG, ROW_TICKS} row_op_t;

  typedef struct {
    row_op_t                         op;
    logic [bpc_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [bpc_pkg::CFG_DATA_W-1:0]  wdata;
    bit                              level;
    int                              reps;
    bit                              typed;
    bpc_pkg::event_kind_t            kind;
    logic [bpc_pkg::LED_IDX_W-1:0]   led;
  } stim_row_t;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 2, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 1, 1'b0, EV_MODE, 4'd0},
    '{ROW_CFG,   R_DEB,     16'hFC01, 1'b0, 0, 1'b0, EV_MODE, 4'd0},
    '{ROW_CFG,   R_LONG,    16'h0004, 1'b0, 0, 1'b0, EV_MODE, 4'd0},
    '{ROW_CFG,   R_LEDS,    16'hFFF2, 1'b0, 0, 1'b0, EV_MODE, 4'd0},
    '{ROW_CFG,   REG_SPARE, 16'h0001, 1'b0, 0, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 5, 1'b1, EV_SEL,  4'd1},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 2, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 3, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 2, 1'b1, EV_MODE, 4'd1},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 1, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 1, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 3, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 1, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 2, 1'b1, EV_SEL,  4'd2},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 2, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 4, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 1, 1'b1, EV_SEL,  4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 2, 1'b0, EV_MODE, 4'd0},
    '{ROW_CFG,   R_LEDS,    16'h0000, 1'b0, 0, 1'b0, EV_MODE, 4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b1, 5, 1'b1, EV_SEL,  4'd0},
    '{ROW_TICKS, R_DEB,     16'h0000, 1'b0, 2, 1'b0, EV_MODE, 4'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  bpc_press_if press_ch ();
  bpc_event_if evt_ch ();
  bpc_cfg_if   cfg_ch ();

  button_press_classifier u_dut (
    .clk   (clk),
    .rst   (rst),
    .press (press_ch),
    .evt   (evt_ch),
    .cfg   (cfg_ch)
  );

  always #6 clk = ~clk;

  // predictor state and its copy of the registers
  bpc_pkg::phase_t                cur_phase;
  logic [bpc_pkg::DEB_W-1:0]      settle_ticks;
  logic [bpc_pkg::LONG_W-1:0]     held_ticks;
  logic [bpc_pkg::LED_IDX_W-1:0]  cur_led;
  logic [bpc_pkg::DEB_W-1:0]      settle_limit;
  logic [bpc_pkg::LONG_W-1:0]     long_limit;
  logic [bpc_pkg::LED_CNT_W-1:0]  num_leds;

  led_event_t pending_events [$];

  bit                            tag_typed;
  bpc_pkg::event_kind_t          tag_kind;
  logic [bpc_pkg::LED_IDX_W-1:0] tag_led;

  int failures       = 0;
  int events_checked = 0;
  int reg_writes     = 0;
  int ticks_sent     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 30;
  int recv_stall_pct = 47;
  int holdoff_reqs   = 0;
  int holdoff_seen   = 0;
  int holdoff_left   = 0;
  int drv_settle     = 1;
  int drv_long       = 4;

  function automatic void bump_hold();
    if (held_ticks != '1) held_ticks++;
  endfunction

  function automatic bit settle_done();
    if (settle_ticks != bpc_pkg::DEB_MAX) settle_ticks++;
    return settle_ticks >= settle_limit;
  endfunction

  function automatic void classify_tick(input bit pressed, output bit fired,
                                        output bpc_pkg::event_kind_t kind,
                                        output logic [bpc_pkg::LED_IDX_W-1:0] led);
    fired = 1'b0;
    kind  = bpc_pkg::EV_MODE_CHANGE;
    led   = '0;
    case (cur_phase)
      bpc_pkg::PH_DEB_PRESS: begin
        bump_hold();
        if (!pressed) cur_phase = bpc_pkg::PH_IDLE;
        else if (settle_done()) cur_phase = bpc_pkg::PH_HELD;
      end
      bpc_pkg::PH_HELD: begin
        bump_hold();
        if (held_ticks >= long_limit) begin
          cur_led   = (cur_led >= bpc_pkg::LED_IDX_W'(num_leds)) ? '0 : cur_led + 1'b1;
          cur_phase = bpc_pkg::PH_WAIT_REL;
          fired     = 1'b1;
          kind      = bpc_pkg::EV_LED_SELECT;
          led       = cur_led;
        end else if (!pressed) begin
          settle_ticks = '0;
          cur_phase    = bpc_pkg::PH_DEB_REL_SHORT;
        end
      end
      bpc_pkg::PH_DEB_REL_SHORT: begin
        bump_hold();
        if (pressed) begin
          cur_phase = bpc_pkg::PH_HELD;
        end else if (settle_done()) begin
          cur_phase = bpc_pkg::PH_IDLE;
          if (cur_led != '0) begin
            fired = 1'b1;
            kind  = bpc_pkg::EV_MODE_CHANGE;
            led   = cur_led;
          end
        end
      end
      bpc_pkg::PH_WAIT_REL: begin
        if (!pressed) begin
          settle_ticks = '0;
          cur_phase    = bpc_pkg::PH_DEB_REL_LONG;
        end
      end
      bpc_pkg::PH_DEB_REL_LONG: begin
        if (pressed) cur_phase = bpc_pkg::PH_WAIT_REL;
        else if (settle_done()) cur_phase = bpc_pkg::PH_IDLE;
      end
      default: begin
        cur_phase = bpc_pkg::PH_IDLE;
        if (pressed) begin
          settle_ticks = '0;
          held_ticks   = '0;
          cur_phase    = bpc_pkg::PH_DEB_PRESS;
        end
      end
    endcase
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH: %s", msg);
  endtask

  always @(posedge clk) begin : check_events
    bit                            fired;
    bpc_pkg::event_kind_t          kind;
    logic [bpc_pkg::LED_IDX_W-1:0] led;
    led_event_t                    want;
    if (rst) begin
      cur_phase    = bpc_pkg::PH_IDLE;
      settle_ticks = '0;
      held_ticks   = '0;
      cur_led      = '0;
      settle_limit = bpc_pkg::DEBOUNCE_TICKS_RESET;
      long_limit   = bpc_pkg::LONG_PRESS_RESET;
      num_leds     = bpc_pkg::LED_COUNT_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          bpc_pkg::REG_DEBOUNCE_TICKS:
            settle_limit = cfg_ch.data[bpc_pkg::DEB_W-1:0];
          bpc_pkg::REG_LONG_PRESS_TICKS:
            long_limit   = cfg_ch.data[bpc_pkg::LONG_W-1:0];
          bpc_pkg::REG_LED_COUNT:
            num_leds     = cfg_ch.data[bpc_pkg::LED_CNT_W-1:0];
          default: ;
        endcase
      end
      if (press_ch.valid && press_ch.ready) begin
        classify_tick(press_ch.button_pressed, fired, kind, led);
        if (tag_typed) begin
          fired = 1'b1;
          kind  = tag_kind;
          led   = tag_led;
        end
        if (fired) begin
          want.kind = kind;
          want.led  = led;
          pending_events.push_back(want);
        end
      end
      if (evt_ch.valid && evt_ch.ready) begin
        events_checked++;
        if (pending_events.size() == 0) begin
          note_failure($sformatf("unexpected result kind %0d led %0d",
                                 evt_ch.event_kind, evt_ch.led_index));
        end else begin
          want = pending_events.pop_front();
          if (evt_ch.event_kind !== want.kind || evt_ch.led_index !== want.led) begin
            note_failure($sformatf("result %0d: kind %0d led %0d, expected kind %0d led %0d",
                                   events_checked, evt_ch.event_kind, evt_ch.led_index,
                                   want.kind, want.led));
          end
        end
      end
    end
  end

  // result side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      evt_ch.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_seen != holdoff_reqs) begin
      holdoff_seen <= holdoff_reqs;
      holdoff_left <= HOLDOFF_CYCLES;
      evt_ch.ready <= 1'b0;
    end else begin
      evt_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_events.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_tick(input bit level, input bit typed,
                           input bpc_pkg::event_kind_t kind,
                           input logic [bpc_pkg::LED_IDX_W-1:0] led);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      press_ch.valid <= 1'b0;
      @(posedge clk);
    end
    press_ch.valid          <= 1'b1;
    press_ch.button_pressed <= level;
    tag_typed               <= typed;
    tag_kind                <= kind;
    tag_led                 <= led;
    @(posedge clk);
    while (!press_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_run(input bit level, input int reps);
    repeat (reps) send_tick(level, 1'b0, EV_MODE, '0);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    press_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_events.size() != 0) begin
      note_failure($sformatf("missing result kind %0d led %0d",
                             pending_events[0].kind, pending_events[0].led));
      void'(pending_events.pop_front());
    end
  endtask

  task automatic write_reg(input logic [bpc_pkg::CFG_INDEX_W-1:0] index,
                           input logic [bpc_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [bpc_pkg::CFG_DATA_W-1:0] deb_data,
                                input logic [bpc_pkg::CFG_DATA_W-1:0] long_data,
                                input logic [bpc_pkg::CFG_DATA_W-1:0] led_data,
                                input bit spare);
    drain();
    write_reg(R_DEB, deb_data);
    write_reg(R_LONG, long_data);
    write_reg(R_LEDS, led_data);
    if (spare) write_reg(REG_SPARE, bpc_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_ch.valid <= 1'b0;
    drv_settle = (deb_data[bpc_pkg::DEB_W-1:0] == '0) ? 1 :
                 int'(deb_data[bpc_pkg::DEB_W-1:0]);
    drv_long   = int'(long_data);
  endtask

  initial begin : stimulus
    row_op_t                        prev_op;
    logic [bpc_pkg::CFG_DATA_W-1:0] deb_data;
    logic [bpc_pkg::CFG_DATA_W-1:0] long_data;
    logic [bpc_pkg::CFG_DATA_W-1:0] led_data;
    int rand_base;
    int phase_end;
    int done;
    int pick;
    int hold_len;
    int rel_len;
    int cut;

    press_ch.valid          <= 1'b0;
    press_ch.button_pressed <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= R_DEB;
    cfg_ch.data             <= '0;
    tag_typed               <= 1'b0;
    tag_kind                <= EV_MODE;
    tag_led                 <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    prev_op = ROW_TICKS;
    foreach (dir_table[i]) begin
      if (dir_table[i].op == ROW_CFG) begin
        if (prev_op == ROW_TICKS) drain();
        write_reg(dir_table[i].reg_index, dir_table[i].wdata);
      end else begin
        if (prev_op == ROW_CFG) cfg_ch.valid <= 1'b0;
        repeat (dir_table[i].reps - 1) send_tick(dir_table[i].level, 1'b0, EV_MODE, '0);
        send_tick(dir_table[i].level, dir_table[i].typed, dir_table[i].kind, dir_table[i].led);
      end
      prev_op = dir_table[i].op;
    end

    // maximum register values, press and bounce well inside them
    apply_settings(16'hFFFF, 16'hFFFF, 16'h000F, 1'b0);
    send_run(1'b1, 20);
    send_run(1'b0, 3);

    // fast long presses against a stalled result side
    apply_settings(16'h0000, 16'h0002, 16'h000F, 1'b0);
    holdoff_reqs <= holdoff_reqs + 1;
    repeat (30) begin
      send_run(1'b1, 3);
      send_run(1'b0, 2);
    end

    rand_base = ticks_sent;
    while (ticks_sent - rand_base < RANDOM_ITEMS) begin
      done = ticks_sent - rand_base;
      if (done < RANDOM_ITEMS / 3) begin
        send_idle_pct  = 30;
        recv_stall_pct = 47;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 47;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      deb_data = bpc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      deb_data[bpc_pkg::DEB_W-1:0] = (pick == 0) ? '0 :
                                     (pick == 1) ? bpc_pkg::DEB_W'(1) :
                                     bpc_pkg::DEB_W'($urandom_range(2, 6));
      pick = $urandom_range(0, 9);
      long_data = (pick == 0) ? bpc_pkg::CFG_DATA_W'($urandom_range(0, 1)) :
                  (pick == 1) ? bpc_pkg::CFG_DATA_W'(2) :
                  bpc_pkg::CFG_DATA_W'($urandom_range(3, 40));
      led_data = bpc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      led_data[bpc_pkg::LED_CNT_W-1:0] = (pick == 0) ? '0 :
                                         (pick == 1) ? bpc_pkg::LED_CNT_W'(15) :
                                         bpc_pkg::LED_CNT_W'($urandom_range(1, 6));
      apply_settings(deb_data, long_data, led_data, $urandom_range(0, 9) < 3);

      phase_end = ticks_sent + $urandom_range(40, 90);
      while (ticks_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)), 1'b0, EV_MODE, '0);
        end else begin
          if ($urandom_range(0, 1) == 1) hold_len = 2 + drv_settle + drv_long + $urandom_range(0, 4);
          else hold_len = $urandom_range(1, drv_long + 1);
          if ($urandom_range(0, 9) == 0) rel_len = $urandom_range(1, drv_settle);
          else rel_len = drv_settle + 1 + $urandom_range(0, 4);
          if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, hold_len);
            send_run(1'b1, cut);
            send_run(1'b0, $urandom_range(1, drv_settle));
            send_run(1'b1, hold_len - cut + 1);
          end else begin
            send_run(1'b1, hold_len);
          end
          if ($urandom_range(0, 4) == 0) begin
            send_run(1'b0, $urandom_range(1, drv_settle));
            send_run(1'b1, $urandom_range(1, 2));
          end
          send_run(1'b0, rel_len);
        end
      end
    end

    drain();
    $display("Run covered %0d button items, %0d results checked, %0d register writes,",
             ticks_sent, events_checked, reg_writes);
    $display("including maximum register values, zero debounce, zero LEDs and a stalled result side.");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
